[rtl/olte_pkg.sv]
`timescale 1ns / 1ps

package olte_pkg;

    typedef struct packed {
        logic [3:0]  action;
        logic [6:0]  index;
        logic [31:0] value;
    } olte_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
        logic [6:0]  length;
    } olte_out_t;

    localparam logic [3:0] ACT_PUSH_BACK  = 4'd0;
    localparam logic [3:0] ACT_POP_BACK   = 4'd1;
    localparam logic [3:0] ACT_PUSH_FRONT = 4'd2;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd3;
    localparam logic [3:0] ACT_INSERT     = 4'd4;
    localparam logic [3:0] ACT_ERASE      = 4'd5;
    localparam logic [3:0] ACT_REMOVE     = 4'd6;
    localparam logic [3:0] ACT_FILL       = 4'd7;
    localparam logic [3:0] ACT_CLEAR      = 4'd8;
    localparam logic [3:0] ACT_ASSIGN     = 4'd9;
    localparam logic [3:0] ACT_READ_AT    = 4'd10;
    localparam logic [3:0] ACT_FRONT      = 4'd11;
    localparam logic [3:0] ACT_BACK       = 4'd12;
    localparam logic [3:0] ACT_RESIZE     = 4'd13;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Datapath walk operations.
    localparam logic [2:0] OP_WRITE  = 3'd0;  // write value over [ptr, end)
    localparam logic [2:0] OP_SHUP   = 3'd1;  // mem[ptr] = mem[ptr-1], ptr down to end
    localparam logic [2:0] OP_SHDN   = 3'd2;  // mem[ptr] = mem[ptr+1], ptr up to end
    localparam logic [2:0] OP_REMOVE = 3'd3;  // compact elements unequal to value
    localparam logic [2:0] OP_READ   = 3'd4;  // read one entry

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } olte_cmd_t;

    typedef struct packed {
        logic done;
    } olte_sts_t;

endpackage

[rtl/olte_datapath.sv]
`timescale 1ns / 1ps

module olte_datapath #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32,
    parameter int AW         = 6,
    parameter int LW         = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  olte_pkg::olte_cmd_t     cmd,
    input  logic [LW-1:0]           first,
    input  logic [LW-1:0]           last,
    input  logic [ELEM_WIDTH-1:0]   wval,
    output olte_pkg::olte_sts_t     sts,
    output logic [ELEM_WIDTH-1:0]   rdata,
    output logic [LW-1:0]           kept
);
    import olte_pkg::*;

    // Walk sub-phases: a read is issued, then the data is used next cycle.
    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_RD   = 2'd1;
    localparam logic [1:0] P_WR   = 2'd2;
    localparam logic [1:0] P_FIN  = 2'd3;

    logic [ELEM_WIDTH-1:0] mem [CAPACITY];

    logic [1:0]            phase_reg, phase_next;
    logic [2:0]            op_reg, op_next;
    logic [LW-1:0]         ptr_reg, ptr_next;
    logic [LW-1:0]         end_reg, end_next;
    logic [LW-1:0]         kept_reg, kept_next;
    logic [ELEM_WIDTH-1:0] q_reg;

    logic                  re, we;
    logic [AW-1:0]         raddr, waddr;
    logic [ELEM_WIDTH-1:0] wdata;

    function automatic logic [AW-1:0] ptr_next_dec(input logic [LW-1:0] p);
        logic [LW-1:0] t;
        t = p - 1'b1;
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_next_inc(input logic [LW-1:0] p);
        logic [LW-1:0] t;
        t = p + 1'b1;
        return t[AW-1:0];
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        kept_next  = kept_reg;
        re         = 1'b0;
        we         = 1'b0;
        raddr      = ptr_reg[AW-1:0];
        waddr      = ptr_reg[AW-1:0];
        wdata      = wval;
        case (phase_reg)
            P_RD:
            begin
                case (op_reg)
                    OP_READ:
                    begin
                        re = 1'b1;
                        phase_next = P_FIN;
                    end
                    OP_SHUP:
                    begin
                        if (ptr_reg == end_reg)
                            phase_next = P_FIN;
                        else
                        begin
                            re = 1'b1;
                            raddr = ptr_next_dec(ptr_reg);
                            phase_next = P_WR;
                        end
                    end
                    OP_SHDN:
                    begin
                        if (ptr_reg + 1'b1 >= end_reg)
                            phase_next = P_FIN;
                        else
                        begin
                            re = 1'b1;
                            raddr = ptr_next_inc(ptr_reg);
                            phase_next = P_WR;
                        end
                    end
                    default:
                    begin
                        if (ptr_reg >= end_reg)
                            phase_next = P_FIN;
                        else
                        begin
                            re = 1'b1;
                            phase_next = P_WR;
                        end
                    end
                endcase
            end
            P_WR:
            begin
                case (op_reg)
                    OP_WRITE:
                    begin
                        if (ptr_reg >= end_reg)
                            phase_next = P_FIN;
                        else
                        begin
                            we = 1'b1;
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    OP_SHUP:
                    begin
                        we = 1'b1;
                        wdata = q_reg;
                        ptr_next = ptr_reg - 1'b1;
                        phase_next = P_RD;
                    end
                    OP_SHDN:
                    begin
                        we = 1'b1;
                        wdata = q_reg;
                        ptr_next = ptr_reg + 1'b1;
                        phase_next = P_RD;
                    end
                    default:
                    begin
                        if (q_reg != wval)
                        begin
                            we = 1'b1;
                            waddr = kept_reg[AW-1:0];
                            wdata = q_reg;
                            kept_next = kept_reg + 1'b1;
                        end
                        ptr_next = ptr_reg + 1'b1;
                        phase_next = P_RD;
                    end
                endcase
            end
            default:
            begin
                // Idle or finishing: a new walk may start in either.
                phase_next = P_IDLE;
                if (cmd.start)
                begin
                    op_next   = cmd.op;
                    ptr_next  = first;
                    end_next  = last;
                    kept_next = '0;
                    phase_next = (cmd.op == OP_WRITE) ? P_WR : P_RD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            op_reg    <= OP_READ;
            ptr_reg   <= '0;
            end_reg   <= '0;
            kept_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            kept_reg  <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            q_reg <= mem[raddr];
    end

    assign sts.done = (phase_reg == P_FIN);
    assign rdata    = q_reg;
    assign kept     = kept_reg;

endmodule

[rtl/olte_ctrl.sv]
`timescale 1ns / 1ps

module olte_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32,
    parameter int LW         = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  olte_pkg::olte_in_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output olte_pkg::olte_out_t   out_item,
    output olte_pkg::olte_cmd_t   cmd,
    output logic [LW-1:0]         first,
    output logic [LW-1:0]         last,
    output logic [ELEM_WIDTH-1:0] wval,
    input  olte_pkg::olte_sts_t   sts,
    input  logic [ELEM_WIDTH-1:0] rdata,
    input  logic [LW-1:0]         kept
);
    import olte_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_WAIT2 = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [LW-1:0] CAP = LW'(CAPACITY);

    logic [2:0]            state_reg, state_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [3:0]            act_reg;
    logic [LW-1:0]         idx_reg;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [1:0]            status_reg, status_next;
    logic                  rdsel_reg, rdsel_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LW-1:0]         second_lo_reg, second_lo_next;
    logic [LW-1:0]         newlen_reg, newlen_next;
    logic                  remove_reg, remove_next;
    logic [ELEM_WIDTH-1:0] rd_reg;
    logic [LW-1:0]         olen_reg;
    logic [1:0]            ostat_reg;

    logic [LW:0]           idx_w;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        status_next    = status_reg;
        rdsel_next     = rdsel_reg;
        out_valid_next = out_valid_reg;
        second_lo_next = second_lo_reg;
        newlen_next    = newlen_reg;
        remove_next    = remove_reg;
        cmd.start      = 1'b0;
        cmd.op         = OP_READ;
        first          = '0;
        last           = '0;
        idx_w          = {1'b0, idx_reg};
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                status_next = ST_OK;
                rdsel_next  = 1'b0;
                newlen_next = len_reg;
                remove_next = 1'b0;
                second_lo_next = len_reg;
                state_next  = S_OUT;
                case (act_reg)
                    ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT:
                    begin
                        if (act_reg == ACT_INSERT && idx_reg > len_reg)
                            status_next = ST_RANGE;
                        else if (len_reg >= CAP)
                            status_next = ST_FULL;
                        else
                        begin
                            // Shift [pos, len) up by one, then write pos.
                            cmd.start = 1'b1;
                            cmd.op    = OP_SHUP;
                            first     = len_reg;
                            last      = (act_reg == ACT_PUSH_BACK) ? len_reg :
                                        (act_reg == ACT_PUSH_FRONT) ? '0 : idx_reg;
                            second_lo_next = last;
                            newlen_next = len_reg + 1'b1;
                            state_next  = S_WAIT1;
                        end
                    end
                    ACT_POP_BACK:
                    begin
                        if (len_reg == '0)
                            status_next = ST_EMPTY;
                        else
                            newlen_next = len_reg - 1'b1;
                    end
                    ACT_POP_FRONT, ACT_ERASE:
                    begin
                        if (act_reg == ACT_ERASE && idx_reg >= len_reg)
                            status_next = ST_RANGE;
                        else if (len_reg == '0)
                            status_next = ST_EMPTY;
                        else
                        begin
                            cmd.start = 1'b1;
                            cmd.op    = OP_SHDN;
                            first     = (act_reg == ACT_ERASE) ? idx_reg : '0;
                            last      = len_reg;
                            newlen_next = len_reg - 1'b1;
                            state_next  = S_WAIT2;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        cmd.start = 1'b1;
                        cmd.op    = OP_REMOVE;
                        first     = '0;
                        last      = len_reg;
                        remove_next = 1'b1;
                        state_next  = S_WAIT2;
                    end
                    ACT_FILL:
                    begin
                        cmd.start = 1'b1;
                        cmd.op    = OP_WRITE;
                        first     = '0;
                        last      = len_reg;
                        state_next = S_WAIT2;
                    end
                    ACT_CLEAR:
                    begin
                        newlen_next = '0;
                    end
                    ACT_ASSIGN, ACT_RESIZE:
                    begin
                        if (idx_w > (LW+1)'(CAPACITY))
                            status_next = ST_FULL;
                        else
                        begin
                            newlen_next = idx_reg;
                            if (act_reg == ACT_ASSIGN || idx_reg > len_reg)
                            begin
                                cmd.start = 1'b1;
                                cmd.op    = OP_WRITE;
                                first     = (act_reg == ACT_ASSIGN) ? '0 : len_reg;
                                last      = idx_reg;
                                state_next = S_WAIT2;
                            end
                        end
                    end
                    ACT_READ_AT, ACT_FRONT, ACT_BACK:
                    begin
                        if (act_reg == ACT_READ_AT && idx_reg >= len_reg)
                            status_next = ST_RANGE;
                        else if (len_reg == '0)
                            status_next = ST_EMPTY;
                        else
                        begin
                            cmd.start = 1'b1;
                            cmd.op    = OP_READ;
                            first     = (act_reg == ACT_READ_AT) ? idx_reg :
                                        (act_reg == ACT_FRONT) ? '0 : len_reg - 1'b1;
                            rdsel_next = 1'b1;
                            state_next = S_WAIT2;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WAIT1:
            begin
                // Shift done; write the new element at its slot.
                if (sts.done)
                begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_WRITE;
                    first     = second_lo_reg;
                    last      = second_lo_reg + 1'b1;
                    state_next = S_WAIT2;
                end
            end
            S_WAIT2:
            begin
                if (sts.done)
                begin
                    if (remove_reg)
                        newlen_next = kept;
                    state_next = S_OUT;
                end
            end
            default:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    len_next       = newlen_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            status_reg    <= ST_OK;
            rdsel_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            second_lo_reg <= '0;
            newlen_reg    <= '0;
            remove_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            status_reg    <= status_next;
            rdsel_reg     <= rdsel_next;
            out_valid_reg <= out_valid_next;
            second_lo_reg <= second_lo_next;
            newlen_reg    <= newlen_next;
            remove_reg    <= remove_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= in_item.action;
            idx_reg <= LW'(in_item.index);
            val_reg <= ELEM_WIDTH'(in_item.value);
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            ostat_reg <= status_reg;
            rd_reg    <= rdsel_reg ? rdata : '0;
            olen_reg  <= newlen_reg;
        end
    end

    // Resize grows the list with zeros; every other walk uses the item value.
    assign in_ready           = (state_reg == S_IDLE);
    assign wval               = (act_reg == ACT_RESIZE) ? '0 : val_reg;
    assign out_valid          = out_valid_reg;
    assign out_item.status    = ostat_reg;
    assign out_item.read_data = 32'(rd_reg);
    assign out_item.length    = 7'(olen_reg);

endmodule

[rtl/ordered_list_table_engine.sv]
`timescale 1ns / 1ps

// Channel | Signals                         | Transaction
// --------+---------------------------------+-------------------------------
// in      | in_valid, in_ready, in_item     | action, index, value
// out     | out_valid, out_ready, out_item  | status, read_data, length
//
// One transaction is worked at a time. Status-only actions need no memory
// walk; reads use a one-entry walk, and walking actions step through the
// element memory one element at a time.
// Reset (rst_n, asynchronous) clears the length and control; the element
// memory is not cleared. A result waits in its output register while the
// next transaction is accepted.
module ordered_list_table_engine #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  olte_pkg::olte_in_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output olte_pkg::olte_out_t out_item
);
    import olte_pkg::*;

    // Address width of the memory and width of a length (0..CAPACITY).
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    olte_cmd_t             cmd;
    olte_sts_t             sts;
    logic [LW-1:0]         first, last, kept;
    logic [ELEM_WIDTH-1:0] wval, rdata;

    olte_ctrl #(
        .CAPACITY  (CAPACITY),
        .ELEM_WIDTH(ELEM_WIDTH),
        .LW        (LW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cmd      (cmd),
        .first    (first),
        .last     (last),
        .wval     (wval),
        .sts      (sts),
        .rdata    (rdata),
        .kept     (kept)
    );

    olte_datapath #(
        .CAPACITY  (CAPACITY),
        .ELEM_WIDTH(ELEM_WIDTH),
        .AW        (AW),
        .LW        (LW)
    ) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .first(first),
        .last (last),
        .wval (wval),
        .sts  (sts),
        .rdata(rdata),
        .kept (kept)
    );

`ifndef NO_ASSERTIONS
    // A result never reports more elements than the memory holds.
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.length <= 7'(CAPACITY)))
        else $error("length above capacity");

    // While a walk finishes, cmd.start and $past(cmd.start) are never both high.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> !(cmd.start && $past(cmd.start)))
        else $error("walk start overlaps");

    // Read data is zero unless the status is ok.
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != ST_OK) |-> (out_item.read_data == '0))
        else $error("read data on failed action");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Testbench for the ordered list engine. A behavioral copy of the list is
// kept here; every accepted request updates it and queues the expected
// response, which the response monitor compares field by field.
module tb;
    import olte_pkg::*;

    localparam int DEPTH        = 64;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    olte_in_t  in_item;
    logic      out_valid;
    logic      out_ready;
    olte_out_t out_item;

    ordered_list_table_engine #(.CAPACITY(DEPTH), .ELEM_WIDTH(32)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the list contents and its length.
    logic [31:0] shadow_list [DEPTH];
    int          shadow_len;
    olte_out_t   pending_resp [$];

    int  error_count;
    int  sent_count;
    int  resp_count;
    int  idle_cycles;
    bit  sender_gaps;
    bit  receiver_gaps;
    bit  hold_receiver;
    int  hold_cycles;
    int  rx_gap;

    // Apply one request to the shadow list and return the response it owes.
    function automatic olte_out_t apply_action(olte_in_t req);
        olte_out_t rsp;
        int        pos;
        int        keep;
        pos = req.index;
        rsp.status    = ST_OK;
        rsp.read_data = '0;
        case (req.action)
            ACT_PUSH_BACK:
                if (shadow_len >= DEPTH) rsp.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = req.value;
                    shadow_len++;
                end
            ACT_POP_BACK:
                if (shadow_len == 0) rsp.status = ST_EMPTY;
                else shadow_len--;
            ACT_PUSH_FRONT, ACT_INSERT:
            begin
                if (req.action == ACT_PUSH_FRONT) pos = 0;
                if (pos > shadow_len) rsp.status = ST_RANGE;
                else if (shadow_len >= DEPTH) rsp.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = req.value;
                    shadow_len++;
                end
            end
            ACT_POP_FRONT, ACT_ERASE:
            begin
                if (req.action == ACT_POP_FRONT) pos = 0;
                if (req.action == ACT_POP_FRONT && shadow_len == 0)
                    rsp.status = ST_EMPTY;
                else if (pos >= shadow_len) rsp.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            ACT_REMOVE:
            begin
                keep = 0;
                for (int i = 0; i < shadow_len; i++)
                    if (shadow_list[i] != req.value)
                    begin
                        shadow_list[keep] = shadow_list[i];
                        keep++;
                    end
                shadow_len = keep;
            end
            ACT_FILL:
                for (int i = 0; i < shadow_len; i++) shadow_list[i] = req.value;
            ACT_CLEAR:
                shadow_len = 0;
            ACT_ASSIGN:
                if (pos > DEPTH) rsp.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < pos; i++) shadow_list[i] = req.value;
                    shadow_len = pos;
                end
            ACT_READ_AT:
                if (pos >= shadow_len) rsp.status = ST_RANGE;
                else rsp.read_data = shadow_list[pos];
            ACT_FRONT:
                if (shadow_len == 0) rsp.status = ST_EMPTY;
                else rsp.read_data = shadow_list[0];
            ACT_BACK:
                if (shadow_len == 0) rsp.status = ST_EMPTY;
                else rsp.read_data = shadow_list[shadow_len-1];
            ACT_RESIZE:
                if (pos > DEPTH) rsp.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i < pos; i++) shadow_list[i] = '0;
                    shadow_len = pos;
                end
            default: ;
        endcase
        rsp.length = 7'(shadow_len);
        return rsp;
    endfunction

    // Offer one request and hold it until the engine takes it. The expected
    // response is queued at the accepting edge. Valid stays high afterwards
    // unless a gap follows, so back-to-back requests keep it high without a drop.
    task automatic send_request(input logic [3:0] act, input int idx,
                                input logic [31:0] val);
        olte_in_t req;
        req.action = act;
        req.index  = 7'(idx);
        req.value  = val;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        pending_resp.push_back(apply_action(req));
        sent_count++;
    endtask

    // Response side: random stall bursts, plus an optional long hold.
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_receiver)
        begin
            out_ready <= 1'b0;
            hold_cycles++;
        end
        else if (rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap--;
        end
        else if (receiver_gaps && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap = $urandom_range(0, 16);
        end
        else out_ready <= 1'b1;
    end

    // Response checker.
    always @(posedge clk)
    begin
        olte_out_t exp_rsp;
        if (rst_n && out_valid && out_ready)
        begin
            resp_count++;
            if (pending_resp.size() == 0)
            begin
                $error("response with nothing pending: %p", out_item);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_resp.pop_front();
                if (out_item.status !== exp_rsp.status)
                begin
                    $error("status expected %0d actual %0d", exp_rsp.status,
                           out_item.status);
                    error_count++;
                end
                if (out_item.read_data !== exp_rsp.read_data)
                begin
                    $error("read_data expected %h actual %h", exp_rsp.read_data,
                           out_item.read_data);
                    error_count++;
                end
                if (out_item.length !== exp_rsp.length)
                begin
                    $error("length expected %0d actual %0d", exp_rsp.length,
                           out_item.length);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("timeout waiting for a transaction");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        // Small values make remove-by-value hit often; wide ones flip every bit.
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 3));
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_edges();
        send_request(ACT_POP_BACK, 0, '0);
        send_request(ACT_POP_FRONT, 0, '0);
        send_request(ACT_FRONT, 0, '0);
        send_request(ACT_BACK, 0, '0);
        send_request(ACT_ERASE, 0, '0);
        send_request(ACT_READ_AT, 0, '0);
        send_request(ACT_INSERT, 1, 32'h1);
        send_request(ACT_PUSH_BACK, 0, 32'hFFFF_FFFF);
        send_request(ACT_PUSH_FRONT, 0, 32'h0);
        send_request(ACT_INSERT, 1, 32'hA5A5_5A5A);
        send_request(ACT_READ_AT, 2, '0);
        send_request(ACT_FRONT, 0, '0);
        send_request(ACT_BACK, 0, '0);
        send_request(ACT_ERASE, 1, '0);
        send_request(ACT_REMOVE, 0, 32'h0);
        send_request(ACT_FILL, 0, 32'h5A5A_A5A5);
        send_request(ACT_ASSIGN, 65, 32'h7);
        send_request(ACT_ASSIGN, 64, 32'h8000_0001);
        send_request(ACT_PUSH_BACK, 0, 32'h1);
        send_request(ACT_INSERT, 64, 32'h1);
        send_request(ACT_INSERT, 127, 32'h1);
        send_request(ACT_READ_AT, 63, '0);
        send_request(ACT_RESIZE, 127, '0);
        send_request(ACT_RESIZE, 0, '0);
        send_request(ACT_RESIZE, 5, '0);
        send_request(4'd14, 127, 32'hFFFF_FFFF);
        send_request(4'd15, 0, '0);
        send_request(ACT_CLEAR, 0, '0);
    endtask

    // Mostly sensible requests that keep the list at mid length; some
    // indexes go out of range on purpose. Resize and assign mostly use
    // small counts so the walks stay short.
    task automatic test_random(input int count);
        logic [3:0] act;
        int         idx;
        for (int n = 0; n < count; n++)
        begin
            act = 4'($urandom_range(0, 15));
            if (act > ACT_RESIZE && $urandom_range(0, 3) != 0)
                act = ACT_PUSH_BACK;
            case ($urandom_range(0, 9))
                0: idx = $urandom_range(0, 127);
                1: idx = $urandom_range(60, 66);
                default: idx = $urandom_range(0, shadow_len + 1);
            endcase
            if ((act == ACT_ASSIGN || act == ACT_RESIZE) && $urandom_range(0, 7) != 0)
                idx = $urandom_range(0, 20);
            send_request(act, idx, rand_value());
        end
    endtask

    // Fill the list to capacity so pushes report full.
    task automatic test_full();
        send_request(ACT_ASSIGN, 60, 32'h3);
        for (int n = 0; n < 6; n++) send_request(ACT_PUSH_FRONT, 0, rand_value());
        send_request(ACT_INSERT, 10, 32'h9);
        send_request(ACT_REMOVE, 0, 32'h3);
    endtask

    // Long receiver hold while requests keep coming.
    task automatic test_backpressure();
        fork
            begin
                hold_receiver = 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 400) @(posedge clk);
                hold_receiver = 1'b0;
            end
            test_random(12);
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        error_count = 0;
        sent_count = 0;
        resp_count = 0;
        idle_cycles = 0;
        hold_receiver = 1'b0;
        hold_cycles = 0;
        rx_gap = 0;
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        shadow_len = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        test_full();
        test_backpressure();
        test_random(900);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random(200);
        in_valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over all actions, empty/full/range cases",
                 sent_count);
        $display("and a long output stall; %0d responses checked.", resp_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[sim.f]
rtl/olte_pkg.sv
rtl/olte_datapath.sv
rtl/olte_ctrl.sv
rtl/ordered_list_table_engine.sv
tb/tb.sv
